### src/dmxbd_pkg.sv
// shared constants and types for the dmx break / mark-after-break detector
`default_nettype none
package dmxbd_pkg;

    // width of the break length counter in microseconds
    localparam int COUNT_WIDTH = 16;

    // configuration register widths and the write data width
    localparam int MIN_WIDTH   = 16;
    localparam int MAX_WIDTH   = 16;
    localparam int TMO_WIDTH   = 8;
    localparam int CFG_WIDTH   = 16;
    localparam int ADDR_WIDTH  = 2;

    // common width for comparing the counter against the bounds
    localparam int CMP_WIDTH   = (COUNT_WIDTH > MIN_WIDTH) ? COUNT_WIDTH : MIN_WIDTH;

    // configuration register indexes
    localparam logic [ADDR_WIDTH-1:0] REG_BREAK_MIN   = 2'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_BREAK_MAX   = 2'd1;
    localparam logic [ADDR_WIDTH-1:0] REG_MARK_TMO    = 2'd2;

    // configuration reset values
    localparam logic [MIN_WIDTH-1:0] BREAK_MIN_RST = 16'd87;
    localparam logic [MAX_WIDTH-1:0] BREAK_MAX_RST = 16'd210;
    localparam logic [TMO_WIDTH-1:0] MARK_TMO_RST  = 8'd20;

    // request kinds
    typedef enum logic [1:0] {
        REQ_EDGE     = 2'd0,
        REQ_US_TICK  = 2'd1,
        REQ_MS_TICK  = 2'd2,
        REQ_FRAME    = 2'd3
    } req_type_t;

    // one result item
    typedef struct packed {
        logic [1:0] detector_phase;
        logic       activity_led;
        logic       receive_enable;
        logic       break_found;
    } result_t;

    // byte padded stream widths
    localparam int IN_TDATA_WIDTH  = 8;
    localparam int OUT_TDATA_WIDTH = 8;
    localparam int RESULT_WIDTH    = $bits(result_t);

endpackage
`default_nettype wire

### src/dmx_break_mark_detector_unit.sv
// top level of the dmx break / mark-after-break detector
`default_nettype none
// DMX break / mark-after-break detector. Each request on the slave stream
// (line edge with new level, microsecond tick, millisecond tick or frame
// finished) yields exactly one result on the master stream with the break
// pulse, the reception enable, the activity LED and the detector phase.
// One request is taken per clock cycle while s_tready is high; its result
// is registered in the output stage; the state update is a single
// compare-and-update pass. A two-entry output stage (result register plus
// skid register) keeps s_tready high while one result waits; s_tready
// drops only while the skid register holds a second result, so the block
// runs at full rate as long as the master side takes a result every cycle.
// Configuration writes take effect at the clock edge of cfg_wr_en.
module dmx_break_mark_detector_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write port
    input  wire logic                                  cfg_wr_en,
    input  wire logic [dmxbd_pkg::ADDR_WIDTH-1:0]      cfg_addr,
    input  wire logic [dmxbd_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
    // request stream
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    input  wire logic [dmxbd_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,  // [0] line_level
    input  wire logic [1:0]                            s_tuser,  // [1:0] req_type
    // result stream
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // [0] break_found, [1] receive_enable, [2] activity_led, [4:3] detector_phase
    output      logic [dmxbd_pkg::OUT_TDATA_WIDTH-1:0] m_tdata
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_MARK  = 2'd2
    } phase_t;

    localparam logic [dmxbd_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [dmxbd_pkg::MIN_WIDTH-1:0] break_min_reg;
    logic [dmxbd_pkg::MAX_WIDTH-1:0] break_max_reg;
    logic [dmxbd_pkg::TMO_WIDTH-1:0] mark_tmo_reg;

    // detector state
    phase_t                            phase_reg,    phase_next;
    logic [dmxbd_pkg::COUNT_WIDTH-1:0] width_reg,    width_next;
    logic                              running_reg,  running_next;
    logic [dmxbd_pkg::TMO_WIDTH-1:0]   timeout_reg,  timeout_next;
    logic                              receive_reg,  receive_next;
    logic                              led_reg,      led_next;
    logic                              found;

    // output stage
    dmxbd_pkg::result_t out_reg, skid_reg, result;
    logic               out_valid_reg, skid_valid_reg;

    logic accept;
    logic out_free;
    logic edge_seen;
    logic [dmxbd_pkg::CMP_WIDTH-1:0] width_ext, min_ext, max_ext;
    dmxbd_pkg::req_type_t req;

    assign req      = dmxbd_pkg::req_type_t'(s_tuser);
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign width_ext = dmxbd_pkg::CMP_WIDTH'(width_reg);
    assign min_ext   = dmxbd_pkg::CMP_WIDTH'(break_min_reg);
    assign max_ext   = dmxbd_pkg::CMP_WIDTH'(break_max_reg);

    // edges count only while reception is off or the timeout has run out
    assign edge_seen = !receive_reg || (timeout_reg == '0);

    // next state for one request
    always_comb begin
        phase_next   = phase_reg;
        width_next   = width_reg;
        running_next = running_reg;
        timeout_next = timeout_reg;
        receive_next = receive_reg;
        led_next     = led_reg;
        found        = 1'b0;
        case (req)
            dmxbd_pkg::REQ_EDGE: begin
                if (edge_seen) begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (!s_tdata[0]) begin
                                width_next   = '0;
                                running_next = 1'b1;
                                phase_next   = PH_BREAK;
                            end
                        end
                        PH_BREAK: begin
                            if (s_tdata[0] && (width_ext > min_ext)
                                    && (width_ext < max_ext)) begin
                                led_next     = 1'b1;
                                phase_next   = PH_MARK;
                                timeout_next = mark_tmo_reg;
                                found        = 1'b1;
                            end else begin
                                phase_next = PH_IDLE;
                            end
                            running_next = 1'b0;
                        end
                        PH_MARK: begin
                            receive_next = !s_tdata[0] && (timeout_reg != '0);
                            phase_next   = PH_IDLE;
                            led_next     = 1'b0;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            dmxbd_pkg::REQ_US_TICK: begin
                if (running_reg && (width_reg != COUNT_MAX)) begin
                    width_next = width_reg + 1'b1;
                end
            end
            dmxbd_pkg::REQ_MS_TICK: begin
                if (timeout_reg != '0) begin
                    timeout_next = timeout_reg - 1'b1;
                end
            end
            default: begin
                receive_next = 1'b0;
            end
        endcase
    end

    // result fields from the updated state
    always_comb begin
        result.break_found    = found;
        result.receive_enable = receive_next;
        result.activity_led   = led_next;
        result.detector_phase = phase_next;
    end

    // state, configuration and output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            break_min_reg  <= dmxbd_pkg::BREAK_MIN_RST;
            break_max_reg  <= dmxbd_pkg::BREAK_MAX_RST;
            mark_tmo_reg   <= dmxbd_pkg::MARK_TMO_RST;
            phase_reg      <= PH_IDLE;
            width_reg      <= '0;
            running_reg    <= 1'b0;
            timeout_reg    <= '0;
            receive_reg    <= 1'b0;
            led_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    dmxbd_pkg::REG_BREAK_MIN: break_min_reg <= cfg_wr_data;
                    dmxbd_pkg::REG_BREAK_MAX: break_max_reg <= cfg_wr_data;
                    dmxbd_pkg::REG_MARK_TMO:
                        mark_tmo_reg <= cfg_wr_data[dmxbd_pkg::TMO_WIDTH-1:0];
                    default: ;
                endcase
            end

            // detector state update per accepted request
            if (accept) begin
                phase_reg   <= phase_next;
                width_reg   <= width_next;
                running_reg <= running_next;
                timeout_reg <= timeout_next;
                receive_reg <= receive_next;
                led_reg     <= led_next;
            end

            // result register with skid stage
            if (skid_valid_reg) begin
                if (out_free) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (out_free) begin
                    out_reg       <= result;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= result;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dmxbd_pkg::OUT_TDATA_WIDTH - dmxbd_pkg::RESULT_WIDTH){1'b0}},
                       out_reg};

endmodule
`default_nettype wire

### bench/dmx_break_detector_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the dmx break / mark-after-break detector
module tb;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_ITEMS = 90;
    localparam int SETTINGS_N  = 8;

    // index with no register behind it, writes to it must be dropped
    localparam logic [dmxbd_pkg::ADDR_WIDTH-1:0] REG_SPARE = 2'd3;

    // detector phases as seen on the result stream
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BREAK = 2'd1;
    localparam logic [1:0] PH_MARK  = 2'd2;

    // tracks detector state and holds the results still owed by the block
    class break_detector_model;
        logic [dmxbd_pkg::MIN_WIDTH-1:0]   min_us;
        logic [dmxbd_pkg::MAX_WIDTH-1:0]   max_us;
        logic [dmxbd_pkg::TMO_WIDTH-1:0]   tmo_ms;
        logic [1:0]                        phase;
        logic [dmxbd_pkg::COUNT_WIDTH-1:0] low_width;
        bit                                running;
        logic [dmxbd_pkg::TMO_WIDTH-1:0]   tmo_left;
        bit                                recv_on;
        bit                                led_on;
        dmxbd_pkg::result_t                owed_q[$];
        int                                fails;

        function new();
            min_us    = dmxbd_pkg::BREAK_MIN_RST;
            max_us    = dmxbd_pkg::BREAK_MAX_RST;
            tmo_ms    = dmxbd_pkg::MARK_TMO_RST;
            phase     = PH_IDLE;
            low_width = '0;
            running   = 1'b0;
            tmo_left  = '0;
            recv_on   = 1'b0;
            led_on    = 1'b0;
            fails     = 0;
        endfunction

        function void set_reg(logic [dmxbd_pkg::ADDR_WIDTH-1:0] idx,
                              logic [dmxbd_pkg::CFG_WIDTH-1:0] val);
            case (idx)
                dmxbd_pkg::REG_BREAK_MIN: min_us = val[dmxbd_pkg::MIN_WIDTH-1:0];
                dmxbd_pkg::REG_BREAK_MAX: max_us = val[dmxbd_pkg::MAX_WIDTH-1:0];
                dmxbd_pkg::REG_MARK_TMO:  tmo_ms = val[dmxbd_pkg::TMO_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // update state for one accepted request and queue its result
        function void note_request(dmxbd_pkg::req_type_t kind, logic level);
            dmxbd_pkg::result_t r;
            bit                 found;
            found = 1'b0;
            case (kind)
                dmxbd_pkg::REQ_EDGE: begin
                    // edges only count while reception is off or the timeout ran out
                    if (!recv_on || tmo_left == 0) begin
                        case (phase)
                            PH_IDLE: begin
                                if (!level) begin
                                    low_width = '0;
                                    running   = 1'b1;
                                    phase     = PH_BREAK;
                                end
                            end
                            PH_BREAK: begin
                                if (level && low_width > min_us && low_width < max_us) begin
                                    led_on   = 1'b1;
                                    phase    = PH_MARK;
                                    tmo_left = tmo_ms;
                                    found    = 1'b1;
                                end else begin
                                    phase = PH_IDLE;
                                end
                                running = 1'b0;
                            end
                            PH_MARK: begin
                                recv_on = !level && tmo_left != 0;
                                phase   = PH_IDLE;
                                led_on  = 1'b0;
                            end
                            default: phase = PH_IDLE;
                        endcase
                    end
                end
                dmxbd_pkg::REQ_US_TICK: begin
                    if (running && low_width != '1) low_width = low_width + 1'b1;
                end
                dmxbd_pkg::REQ_MS_TICK: begin
                    if (tmo_left != 0) tmo_left = tmo_left - 1'b1;
                end
                default: recv_on = 1'b0;
            endcase
            r.break_found    = found;
            r.receive_enable = recv_on;
            r.activity_led   = led_on;
            r.detector_phase = phase;
            owed_q.push_back(r);
        endfunction

        function void check_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                fails++;
            end
        endfunction

        // compare one result word with the oldest owed result
        function void check_result(logic [dmxbd_pkg::OUT_TDATA_WIDTH-1:0] word);
            dmxbd_pkg::result_t want;
            dmxbd_pkg::result_t got;
            if (owed_q.size() == 0) begin
                $error("result %h arrived with nothing owed", word);
                fails++;
                return;
            end
            want = owed_q.pop_front();
            got  = word[dmxbd_pkg::RESULT_WIDTH-1:0];
            check_field("break_found", 3'(want.break_found), 3'(got.break_found));
            check_field("receive_enable", 3'(want.receive_enable),
                        3'(got.receive_enable));
            check_field("activity_led", 3'(want.activity_led), 3'(got.activity_led));
            check_field("detector_phase", 3'(want.detector_phase),
                        3'(got.detector_phase));
            check_field("tdata padding", '0,
                        word[dmxbd_pkg::OUT_TDATA_WIDTH-1:dmxbd_pkg::RESULT_WIDTH]);
        endfunction
    endclass

    logic                                  aclk        = 1'b0;
    logic                                  aresetn     = 1'b0;
    logic                                  cfg_wr_en   = 1'b0;
    logic [dmxbd_pkg::ADDR_WIDTH-1:0]      cfg_addr    = '0;
    logic [dmxbd_pkg::CFG_WIDTH-1:0]       cfg_wr_data = '0;
    logic                                  s_tvalid    = 1'b0;
    logic                                  s_tready;
    logic [dmxbd_pkg::IN_TDATA_WIDTH-1:0]  s_tdata     = '0;
    logic [1:0]                            s_tuser     = '0;
    logic                                  m_tvalid;
    logic                                  m_tready    = 1'b0;
    logic [dmxbd_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;

    break_detector_model model;
    int  cycle_count = 0;
    int  sent_count  = 0;
    bit  src_calm    = 1'b0;
    int  cfg_lo      = dmxbd_pkg::BREAK_MIN_RST;
    int  cfg_hi      = dmxbd_pkg::BREAK_MAX_RST;
    int  cfg_tmo     = dmxbd_pkg::MARK_TMO_RST;
    int  sink_wait   = 0;
    int  sink_taken  = 0;
    bit  sink_calm   = 1'b0;

    dmx_break_mark_detector_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_wait  <= 0;
            sink_taken <= 0;
            sink_calm  <= 1'b0;
        end else begin
            if (cycle_count % 256 == 0) sink_calm <= ($urandom_range(0, 2) == 0);
            if (m_tvalid && m_tready) sink_taken <= sink_taken + 1;
            if (sink_wait != 0) begin
                m_tready  <= 1'b0;
                sink_wait <= sink_wait - 1;
            end else if (m_tvalid && m_tready && (sink_taken == 60 || sink_taken == 600)) begin
                // long hold so the output stage fills and the input side stalls
                m_tready  <= 1'b0;
                sink_wait <= 90;
            end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
                m_tready  <= 1'b0;
                sink_wait <= pick_gap() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watch both handshakes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) model.check_result(m_tdata);
            if (s_tvalid && s_tready)
                model.note_request(dmxbd_pkg::req_type_t'(s_tuser), s_tdata[0]);
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(input dmxbd_pkg::req_type_t kind, input bit level);
        int gap;
        gap = 0;
        if (!src_calm && $urandom_range(0, 3) == 0) gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(dmxbd_pkg::IN_TDATA_WIDTH-1){1'b0}}, level};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // stop offering and let every owed result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (model.pending() != 0 || m_tvalid) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [dmxbd_pkg::ADDR_WIDTH-1:0] idx,
                             input logic [dmxbd_pkg::CFG_WIDTH-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        model.set_reg(idx, val);
    endtask

    // new bounds and timeout, only with the block drained
    task automatic configure(input int lo, input int hi, input int tmo);
        settle();
        write_reg(dmxbd_pkg::REG_BREAK_MIN, dmxbd_pkg::CFG_WIDTH'(lo));
        write_reg(dmxbd_pkg::REG_BREAK_MAX, dmxbd_pkg::CFG_WIDTH'(hi));
        write_reg(dmxbd_pkg::REG_MARK_TMO, dmxbd_pkg::CFG_WIDTH'(tmo));
        write_reg(REG_SPARE, dmxbd_pkg::CFG_WIDTH'($urandom_range(0, 16'hFFFF)));
        cfg_wr_en <= 1'b0;
        cfg_lo  = lo;
        cfg_hi  = hi;
        cfg_tmo = tmo;
    endtask

    // one break, mark and frame with random lengths and some noise
    task automatic break_attempt();
        int lower;
        int upper;
        int low_len;
        int ms_len;
        src_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 5) == 0) send_request(dmxbd_pkg::REQ_EDGE, 1'b1);
        repeat ($urandom_range(0, 2))
            send_request(dmxbd_pkg::req_type_t'($urandom_range(1, 3)),
                         1'($urandom_range(0, 1)));
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        // low time mostly around the configured window
        if (cfg_lo > 400) begin
            lower = 0;
            upper = 20;
        end else begin
            lower = (cfg_lo > 0) ? cfg_lo - 1 : 0;
            upper = (cfg_hi + 1 < cfg_lo + 40) ? cfg_hi + 1 : cfg_lo + 40;
            if (upper < lower) upper = lower + 2;
        end
        low_len = $urandom_range(lower, upper);
        for (int i = 0; i < low_len; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_request(dmxbd_pkg::req_type_t'($urandom_range(2, 3)),
                             1'($urandom_range(0, 1)));
            send_request(dmxbd_pkg::REQ_US_TICK, 1'($urandom_range(0, 1)));
        end
        // now and then the line falls again instead of rising
        send_request(dmxbd_pkg::REQ_EDGE, $urandom_range(0, 11) != 0);
        // mark time around the timeout
        if (cfg_tmo > 30 && $urandom_range(0, 3) != 0) ms_len = $urandom_range(0, 30);
        else ms_len = $urandom_range(0, cfg_tmo + 1);
        for (int i = 0; i < ms_len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(dmxbd_pkg::REQ_US_TICK, 1'($urandom_range(0, 1)));
            send_request(dmxbd_pkg::REQ_MS_TICK, 1'($urandom_range(0, 1)));
        end
        send_request(dmxbd_pkg::REQ_EDGE, $urandom_range(0, 9) < 3);
        // slot traffic, edges here are mostly ignored
        repeat ($urandom_range(0, 4))
            send_request(dmxbd_pkg::req_type_t'($urandom_range(0, 2)),
                         1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0)
            send_request(dmxbd_pkg::REQ_FRAME, 1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        int lo_set [SETTINGS_N] = '{3, 0, 0, 10, 65535, 1, 20, 2};
        int hi_set [SETTINGS_N] = '{9, 0, 5, 30, 65535, 3, 60, 65535};
        int tmo_set[SETTINGS_N] = '{4, 0, 255, 1, 2, 8, 6, 5};
        int goal;
        model = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle corner cases with reset settings
        src_calm = 1'b1;
        send_request(dmxbd_pkg::REQ_EDGE, 1'b1);     // rising edge in idle
        send_request(dmxbd_pkg::REQ_FRAME, 1'b0);
        send_request(dmxbd_pkg::REQ_MS_TICK, 1'b1);  // timeout already zero
        send_request(dmxbd_pkg::REQ_US_TICK, 1'b0);  // counter not running
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_US_TICK, 1'b1);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);     // falling again while measuring
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b1);     // break far too short

        // accepted break, reception on, edges ignored until timeout runs out
        configure(1, 3, 2);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_US_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_US_TICK, 1'b1);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b1);
        send_request(dmxbd_pkg::REQ_MS_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_MS_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b1);
        send_request(dmxbd_pkg::REQ_FRAME, 1'b1);
        // break then mark outlasting the timeout
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);
        send_request(dmxbd_pkg::REQ_US_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_US_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b1);
        send_request(dmxbd_pkg::REQ_MS_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_MS_TICK, 1'b0);
        send_request(dmxbd_pkg::REQ_EDGE, 1'b0);

        // random sequences under several settings
        for (int k = 0; k < SETTINGS_N; k++) begin
            configure(lo_set[k], hi_set[k], tmo_set[k]);
            goal = sent_count + PHASE_ITEMS;
            while (sent_count < goal) break_attempt();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (model.fails == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
